// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the wheel speed RTL.
// Requires a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define WSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define WSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/wsp_pkg.sv =====
// Package for the wheel speed block: types, register indexes, reset values.
// No dependencies.
`default_nettype none

package wsp_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] TICKS_PER_UNIT  = 32'd100;
    localparam logic [DATA_W-1:0] RST_SPEED_CONST = 32'd0;
    localparam logic [DATA_W-1:0] RST_TIMEOUT_US  = 32'd1000000;
    localparam logic [DATA_W-1:0] RST_MIN_IVL_US  = 32'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IVL_US  = 2'd2;

    localparam logic KIND_EDGE = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] speed_constant;
        logic [DATA_W-1:0] timeout_us;
        logic [DATA_W-1:0] min_interval_us;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_TICKS,
        ST_DIV_SPEED,
        ST_PUSH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/wsp_cfg.sv =====
// Configuration register file for the wheel speed block.
// Depends on wsp_pkg.
`default_nettype none

module wsp_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wsp_pkg::DATA_W-1:0]     cfg_data,
    output wsp_pkg::cfg_t                       cfg
);

    wsp_pkg::cfg_t cfg_reg;
    wsp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                wsp_pkg::REG_SPEED_CONST: cfg_next.speed_constant  = cfg_data;
                wsp_pkg::REG_TIMEOUT_US:  cfg_next.timeout_us      = cfg_data;
                wsp_pkg::REG_MIN_IVL_US:  cfg_next.min_interval_us = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_constant  <= wsp_pkg::RST_SPEED_CONST;
            cfg_reg.timeout_us      <= wsp_pkg::RST_TIMEOUT_US;
            cfg_reg.min_interval_us <= wsp_pkg::RST_MIN_IVL_US;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wsp_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wsp_pkg. A zero divisor yields an all-ones quotient.
`default_nettype none

module wsp_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [wsp_pkg::DATA_W-1:0]  dividend,
    input  wire logic [wsp_pkg::DATA_W-1:0]  divisor,
    output logic                             done,
    output logic [wsp_pkg::DATA_W-1:0]       quotient
);

    localparam int unsigned W   = wsp_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [W-1:0]     quo_reg,   quo_next;
    logic [W-1:0]     rem_reg,   rem_next;
    logic [W-1:0]     dvs_reg,   dvs_next;
    logic [W+1:0]     trial;
    logic             fits;

    assign trial    = {1'b0, rem_reg, quo_reg[W-1]} - {2'b00, dvs_reg};
    assign fits     = !trial[W+1];
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[W-2:0], fits};
            rem_next = fits ? trial[W-1:0] : {rem_reg[W-2:0], quo_reg[W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/wheel_speed_from_pulse_period.sv =====
// A stop check or bounced edge goes from acceptance through ST_PUSH into the output
// register; an accepted edge first runs two serial divides (interval / 100, then
// constant / that quotient) in ST_DIV_TICKS and ST_DIV_SPEED. One item at a time:
// the next is accepted the cycle after the result is queued; output stalls hold ST_PUSH.
// Reset (aresetn, synchronous, active low) restores state and registers to defaults.
// Depends on wsp_pkg, wsp_cfg, wsp_div and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wheel_speed_from_pulse_period (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wsp_pkg::DATA_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_kind,
    input  wire logic [wsp_pkg::DATA_W-1:0]     s_time_us,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [wsp_pkg::DATA_W-1:0]          m_speed_x100,
    output logic                                m_accepted,
    output logic                                m_stopped,
    output logic [wsp_pkg::DATA_W-1:0]          m_pulse_count
);

    localparam int unsigned W = wsp_pkg::DATA_W;

    wsp_pkg::cfg_t  cfg;
    wsp_pkg::state_t state_reg, state_next;

    logic [W-1:0] last_edge_reg, speed_reg, count_reg;
    logic         acc_reg, stop_reg;
    logic         m_valid_reg;
    logic [W-1:0] m_speed_reg, m_count_reg;
    logic         m_acc_reg, m_stop_reg;

    logic [W-1:0] gap_us;
    logic         edge_ok, stop_hit, take, push;
    logic         div_start, div_done;
    logic [W-1:0] div_dividend, div_divisor, div_quotient;
    logic         dividing;

    wsp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wsp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign gap_us   = s_time_us - last_edge_reg;
    assign edge_ok  = (s_kind == wsp_pkg::KIND_EDGE) && (gap_us >= cfg.min_interval_us);
    assign stop_hit = (s_kind != wsp_pkg::KIND_EDGE) && (gap_us > cfg.timeout_us);
    assign take     = s_valid && s_ready;
    assign dividing = (state_reg == wsp_pkg::ST_DIV_TICKS) ||
                      (state_reg == wsp_pkg::ST_DIV_SPEED);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wsp_pkg::ST_IDLE: begin
                if (take) begin
                    state_next = edge_ok ? wsp_pkg::ST_DIV_TICKS : wsp_pkg::ST_PUSH;
                end
            end
            wsp_pkg::ST_DIV_TICKS: begin
                if (div_done) begin
                    state_next = wsp_pkg::ST_DIV_SPEED;
                end
            end
            wsp_pkg::ST_DIV_SPEED: begin
                if (div_done) begin
                    state_next = wsp_pkg::ST_PUSH;
                end
            end
            wsp_pkg::ST_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = wsp_pkg::ST_IDLE;
                end
            end
            default: state_next = wsp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == wsp_pkg::ST_IDLE);
        div_start    = 1'b0;
        div_dividend = gap_us;
        div_divisor  = wsp_pkg::TICKS_PER_UNIT;
        push         = 1'b0;
        case (state_reg)
            wsp_pkg::ST_IDLE: begin
                div_start = take && edge_ok;
            end
            wsp_pkg::ST_DIV_TICKS: begin
                div_start    = div_done;
                div_dividend = cfg.speed_constant;
                div_divisor  = div_quotient;
            end
            wsp_pkg::ST_PUSH: begin
                push = !m_valid_reg || m_ready;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wsp_pkg::ST_IDLE;
            last_edge_reg <= '0;
            speed_reg     <= '0;
            count_reg     <= '0;
            acc_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (take) begin
                acc_reg  <= edge_ok;
                stop_reg <= stop_hit;
                if (edge_ok) begin
                    last_edge_reg <= s_time_us;
                    count_reg     <= count_reg + 1'b1;
                end
                if (stop_hit) begin
                    speed_reg <= '0;
                end
            end
            if ((state_reg == wsp_pkg::ST_DIV_SPEED) && div_done) begin
                speed_reg <= div_quotient;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (push) begin
            m_speed_reg <= speed_reg;
            m_acc_reg   <= acc_reg;
            m_stop_reg  <= stop_reg;
            m_count_reg <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_speed_x100  = m_speed_reg;
    assign m_accepted    = m_acc_reg;
    assign m_stopped     = m_stop_reg;
    assign m_pulse_count = m_count_reg;

    `WSP_ASSERT(a_take_leaves_idle, take |=> (state_reg != wsp_pkg::ST_IDLE), "still idle")
    `WSP_ASSERT(a_div_done_in_div, div_done |-> dividing, "divider done outside a divide")
    `WSP_ASSERT(a_flags_exclusive, m_valid |-> !(m_accepted && m_stopped), "both flags set")
    `WSP_ASSERT(a_count_on_accept, (take && edge_ok) |=> (count_reg == $past(count_reg) + 1'b1), "count stuck")

endmodule

`default_nettype wire

// ===== tb/wsp_speed_checker.sv =====
// Checker for the wheel speed block: watches the register, event and speed channels,
// predicts each speed item from its own copy of the registers and state, and compares.
// Depends on wsp_pkg.
module wsp_speed_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wsp_pkg::DATA_W-1:0]        cfg_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_kind,
    input  logic [wsp_pkg::DATA_W-1:0]        s_time_us,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [wsp_pkg::DATA_W-1:0]        m_speed_x100,
    input  logic                              m_accepted,
    input  logic                              m_stopped,
    input  logic [wsp_pkg::DATA_W-1:0]        m_pulse_count,
    output int                                mismatches,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] speed;
        logic              accepted;
        logic              stopped;
        logic [DATA_W-1:0] count;
    } speed_item_t;

    cfg_t              tach_regs;
    logic [DATA_W-1:0] last_edge_us;
    logic [DATA_W-1:0] held_speed;
    logic [DATA_W-1:0] edge_total;
    speed_item_t       expected_speeds[$];
    int                error_total = 0;

    function automatic speed_item_t advance_tach(input logic kind,
                                                 input logic [DATA_W-1:0] t_us);
        logic [DATA_W-1:0] gap_us;
        logic [DATA_W-1:0] ticks;
        speed_item_t       r;
        gap_us     = t_us - last_edge_us;
        r.accepted = 1'b0;
        r.stopped  = 1'b0;
        if (kind == KIND_EDGE) begin
            if (gap_us >= tach_regs.min_interval_us) begin
                ticks        = gap_us / TICKS_PER_UNIT;
                held_speed   = (ticks == '0) ? '1 : tach_regs.speed_constant / ticks;
                last_edge_us = t_us;
                edge_total   = edge_total + 1'b1;
                r.accepted   = 1'b1;
            end
        end else if (gap_us > tach_regs.timeout_us) begin
            held_speed = '0;
            r.stopped  = 1'b1;
        end
        r.speed = held_speed;
        r.count = edge_total;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        speed_item_t got;
        speed_item_t want;
        if (!aresetn) begin
            tach_regs.speed_constant  = RST_SPEED_CONST;
            tach_regs.timeout_us      = RST_TIMEOUT_US;
            tach_regs.min_interval_us = RST_MIN_IVL_US;
            last_edge_us = '0;
            held_speed   = '0;
            edge_total   = '0;
            expected_speeds.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPEED_CONST: tach_regs.speed_constant  = cfg_data;
                    REG_TIMEOUT_US:  tach_regs.timeout_us      = cfg_data;
                    REG_MIN_IVL_US:  tach_regs.min_interval_us = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_speeds.push_back(advance_tach(s_kind, s_time_us));
            if (m_valid && m_ready) begin
                got = '{m_speed_x100, m_accepted, m_stopped, m_pulse_count};
                if (expected_speeds.size() == 0) begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: unexpected item speed %0d acc %0b stop %0b count %0d",
                                 $realtime, got.speed, got.accepted, got.stopped, got.count);
                end else begin
                    want = expected_speeds.pop_front();
                    if (got !== want) begin
                        error_total++;
                        if (error_total <= 10) begin
                            $write("%0t: mismatch: exp speed %0d acc %0b stop %0b count %0d",
                                   $realtime, want.speed, want.accepted, want.stopped,
                                   want.count);
                            $display(", got speed %0d acc %0b stop %0b count %0d",
                                     got.speed, got.accepted, got.stopped, got.count);
                        end
                    end
                end
            end
        end
        mismatches <= error_total;
        pending    <= expected_speeds.size();
    end

endmodule

// ===== tb/tb_wheel_speed_from_pulse_period.sv =====
// Top of the wheel speed testbench: clock, reset, register writes and timestamped
// edge / stop-check stimulus with random idling on both channels; gives the verdict.
// Depends on wsp_pkg, wheel_speed_from_pulse_period and wsp_speed_checker.
module tb_wheel_speed_from_pulse_period;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    localparam logic KIND_STOP   = ~KIND_EDGE;
    localparam int   CYCLE_LIMIT = 1_000_000;
    localparam int   SETTLE      = 80;
    localparam int   BLOCKS      = 19;
    localparam int   BLOCK_ITEMS = 100;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_SPEED_CONST;
    logic [DATA_W-1:0]    cfg_data      = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_kind        = KIND_EDGE;
    logic [DATA_W-1:0]    s_time_us     = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [DATA_W-1:0]    m_speed_x100;
    logic                 m_accepted;
    logic                 m_stopped;
    logic [DATA_W-1:0]    m_pulse_count;

    int                   mismatches;
    int                   pending;
    int                   cycle_count   = 0;
    int                   send_idle_pct = 37;
    int                   recv_idle_pct = 77;

    logic [DATA_W-1:0]    timeout_now   = RST_TIMEOUT_US;
    logic [DATA_W-1:0]    min_ivl_now   = RST_MIN_IVL_US;
    logic [DATA_W-1:0]    edge_anchor   = '0;

    wheel_speed_from_pulse_period u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_time_us     (s_time_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed_x100  (m_speed_x100),
        .m_accepted    (m_accepted),
        .m_stopped     (m_stopped),
        .m_pulse_count (m_pulse_count)
    );

    wsp_speed_checker u_tach_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_time_us     (s_time_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed_x100  (m_speed_x100),
        .m_accepted    (m_accepted),
        .m_stopped     (m_stopped),
        .m_pulse_count (m_pulse_count),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready     <= ($urandom_range(0, 99) >= recv_idle_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_event(input logic kind, input logic [DATA_W-1:0] t_us);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_time_us <= t_us;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_tach_regs(input logic [DATA_W-1:0] speed_k,
                                  input logic [DATA_W-1:0] timeout,
                                  input logic [DATA_W-1:0] min_ivl);
        wait_drained();
        write_reg(REG_SPEED_CONST, speed_k);
        write_reg(REG_TIMEOUT_US, timeout);
        write_reg(REG_MIN_IVL_US, min_ivl);
        timeout_now = timeout;
        min_ivl_now = min_ivl;
    endtask

    task automatic load_random_regs();
        logic [DATA_W-1:0] speed_k;
        logic [DATA_W-1:0] timeout;
        logic [DATA_W-1:0] min_ivl;
        case ($urandom_range(0, 7))
            0:       speed_k = '0;
            1:       speed_k = '1;
            2, 3:    speed_k = $urandom;
            default: speed_k = $urandom_range(1000, 200_000_000);
        endcase
        case ($urandom_range(0, 7))
            0:       min_ivl = '0;
            1:       min_ivl = $urandom_range(1, 150);
            2:       min_ivl = $urandom;
            default: min_ivl = $urandom_range(500, 5000);
        endcase
        case ($urandom_range(0, 7))
            0:       timeout = '0;
            1:       timeout = $urandom;
            2:       timeout = '1;
            default: timeout = $urandom_range(10_000, 3_000_000);
        endcase
        load_tach_regs(speed_k, timeout, min_ivl);
    endtask

    // Mostly coherent wheel activity measured from the last accepted edge,
    // with bounce, stop checks around the timeout, and some random noise.
    task automatic send_random_event();
        logic [DATA_W-1:0] delta;
        logic [DATA_W-1:0] t_us;
        logic              kind;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        kind = KIND_EDGE;
        if (pick < 55) begin
            case ($urandom_range(0, 3))
                0:       delta = min_ivl_now;
                1:       delta = min_ivl_now + $urandom_range(0, 20_000);
                2:       delta = min_ivl_now + $urandom_range(0, 2_000_000);
                default: delta = min_ivl_now + $urandom_range(0, 200);
            endcase
        end else if (pick < 70) begin
            if (min_ivl_now == '0)
                delta = $urandom_range(0, 50);
            else if ($urandom_range(0, 1) == 0)
                delta = min_ivl_now - 1'b1;
            else
                delta = $urandom_range(0, min_ivl_now - 1);
        end else if (pick < 93) begin
            kind = KIND_STOP;
            case ($urandom_range(0, 3))
                0:       delta = timeout_now;
                1:       delta = timeout_now + 1'b1;
                2:       delta = $urandom_range(0, timeout_now);
                default: delta = timeout_now + $urandom_range(0, 100_000);
            endcase
        end else begin
            kind  = $urandom_range(0, 1) ? KIND_STOP : KIND_EDGE;
            delta = $urandom - edge_anchor;
        end
        t_us = edge_anchor + delta;
        if (kind == KIND_EDGE && delta >= min_ivl_now && pick < 93)
            edge_anchor = t_us;
        send_event(kind, t_us);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: first edge against time zero, zero speed constant
        send_event(KIND_EDGE, 32'd5000);
        send_event(KIND_STOP, 32'd6000);

        // no bounce filter, zero timeout, full-scale constant: zero interval saturates
        load_tach_regs('1, '0, '0);
        send_event(KIND_EDGE, 32'd6000);
        send_event(KIND_EDGE, 32'd6000);
        send_event(KIND_EDGE, 32'd6099);
        send_event(KIND_STOP, 32'd6099);
        send_event(KIND_STOP, 32'd6100);
        send_event(KIND_EDGE, 32'd6000);
        send_event(KIND_EDGE, 32'hFFFF_FFFF);
        send_event(KIND_EDGE, 32'd0);

        // largest bounce window and timeout, time wrapping
        load_tach_regs(32'd12_345_678, '1, '1);
        send_event(KIND_EDGE, 32'd0);
        send_event(KIND_EDGE, 32'hFFFF_FFFF);
        send_event(KIND_STOP, 32'hFFFF_FFFE);
        send_event(KIND_EDGE, 32'd5);

        // default bounce window and timeout, boundaries on both
        load_tach_regs(32'd3_600_000, RST_TIMEOUT_US, RST_MIN_IVL_US);
        send_event(KIND_EDGE, 32'd1999);
        send_event(KIND_EDGE, 32'd3998);
        send_event(KIND_STOP, 32'd1_001_999);
        send_event(KIND_STOP, 32'd1_002_000);
        send_event(KIND_EDGE, 32'd4499);
        edge_anchor = 32'd4499;

        for (int blk = 0; blk < BLOCKS; blk++) begin
            load_random_regs();
            if (blk < 7) begin
                send_idle_pct  = 37;
                recv_idle_pct <= 77;
            end else if (blk < 13) begin
                send_idle_pct  = 77;
                recv_idle_pct <= 37;
            end else begin
                send_idle_pct  = 0;
                recv_idle_pct <= 0;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_random_event();
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== wheel_speed_from_pulse_period.f =====
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_cfg.sv
rtl/core/wsp_div.sv
rtl/core/wheel_speed_from_pulse_period.sv
tb/wsp_speed_checker.sv
tb/tb_wheel_speed_from_pulse_period.sv
